[rtl/dws_pkg.sv]
// Shared types and constants for the deque with search.
`default_nettype none
package dws_pkg;

   localparam int FUNC_W   = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 7;

   // request function codes
   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd4;
   localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] element;
      logic [POS_W-1:0]         position;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

endpackage
`default_nettype wire

[rtl/dws_ram.sv]
// Element store: one write port, one registered read port.
`default_nettype none
module dws_ram #(
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire dws_pkg::ram_ctl_type          ctl,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic signed [dws_pkg::DATA_W-1:0] wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic signed [dws_pkg::DATA_W-1:0]  rd_data
);
   import dws_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/dws_ctrl.sv]
// Request sequencer: ring pointers, store walk for dump/search, response register.
`default_nettype none
module dws_ctrl #(
   parameter int DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [dws_pkg::FUNC_W-1:0]        req_func,
   input  wire logic signed [dws_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output dws_pkg::rsp_type                       rsp,
   output dws_pkg::ram_ctl_type                   ram_ctl,
   output logic [$clog2(DEPTH)-1:0]               ram_wr_addr,
   output logic signed [dws_pkg::DATA_W-1:0]      ram_wr_data,
   output logic [$clog2(DEPTH)-1:0]               ram_rd_addr,
   input  wire logic signed [dws_pkg::DATA_W-1:0] ram_rd_data
);
   import dws_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [AW-1:0]            front_ff, front_in;
   logic [CW-1:0]            occ_ff, occ_in;
   logic                     dump_ff, dump_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CW-1:0]            rd_cnt_ff, rd_cnt_in;
   logic [AW-1:0]            rd_addr_ff, rd_addr_in;
   logic                     d_vld_ff, d_vld_in;
   logic [CW-1:0]            d_num_ff, d_num_in;
   rsp_type                  pend_ff, pend_in;
   logic                     out_vld_ff, out_vld_in;
   rsp_type                  out_ff, out_in;

   logic          accept, out_free, is_full, is_empty;
   logic [AW-1:0] front_dec, front_inc, tail, rd_addr_inc;
   logic [SW-1:0] tail_sum;
   logic          issue, consume, finish, match, d_last;
   logic          out_load;
   rsp_type       res;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !out_vld_ff || rsp_ready;
   assign is_full  = (occ_ff == CW'(DEPTH));
   assign is_empty = (occ_ff == '0);

   // ring index arithmetic
   assign front_dec   = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc   = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign rd_addr_inc = (rd_addr_ff == AW'(DEPTH - 1)) ? '0 : rd_addr_ff + AW'(1);
   assign tail_sum    = SW'(front_ff) + SW'(occ_ff);
   assign tail        = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                 : AW'(tail_sum);

   // walk pipeline: one read in flight, drained into the response register
   assign consume = (state_ff == S_WALK) && d_vld_ff && out_free;
   assign issue   = (state_ff == S_WALK) && (rd_cnt_ff != occ_ff) && (!d_vld_ff || consume);
   assign match   = (ram_rd_data == key_ff);
   assign d_last  = (d_num_ff == occ_ff);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      occ_in      = occ_ff;
      dump_in     = dump_ff;
      key_in      = key_ff;
      rd_cnt_in   = rd_cnt_ff;
      rd_addr_in  = rd_addr_ff;
      d_vld_in    = d_vld_ff;
      d_num_in    = d_num_ff;
      pend_in     = pend_ff;
      ram_ctl     = '0;
      ram_wr_addr = front_dec;
      ram_rd_addr = rd_addr_ff;
      out_load    = 1'b0;
      finish      = 1'b0;
      res         = '{status: ST_OK, element: '0, position: '0, last: 1'b1};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_load = 1'b1;
               case (req_func)
                  FN_PUSH_FRONT: begin
                     if (is_full) begin
                        res.status = ST_FULL;
                     end else begin
                        ram_ctl.wr_en = 1'b1;
                        ram_wr_addr   = front_dec;
                        front_in      = front_dec;
                        occ_in        = occ_ff + CW'(1);
                     end
                  end
                  FN_PUSH_BACK: begin
                     if (is_full) begin
                        res.status = ST_FULL;
                     end else begin
                        ram_ctl.wr_en = 1'b1;
                        ram_wr_addr   = tail;
                        occ_in        = occ_ff + CW'(1);
                     end
                  end
                  FN_POP_FRONT: begin
                     if (is_empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        front_in = front_inc;
                        occ_in   = occ_ff - CW'(1);
                     end
                  end
                  FN_POP_BACK: begin
                     if (is_empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        occ_in = occ_ff - CW'(1);
                     end
                  end
                  FN_DUMP, FN_SEARCH: begin
                     if (is_empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        out_load   = 1'b0;
                        state_in   = S_WALK;
                        dump_in    = (req_func == FN_DUMP);
                        key_in     = req_value;
                        rd_cnt_in  = '0;
                        rd_addr_in = front_ff;
                        d_vld_in   = 1'b0;
                     end
                  end
                  default: begin
                     res.status = ST_OK;
                  end
               endcase
               // park the single response if the output is still occupied
               if (out_load && !out_free) begin
                  out_load = 1'b0;
                  pend_in  = res;
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            res = pend_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (consume) begin
               if (dump_ff) begin
                  out_load    = 1'b1;
                  res.element = ram_rd_data;
                  res.last    = d_last;
                  finish      = d_last;
               end else if (match) begin
                  out_load     = 1'b1;
                  res.position = POS_W'(d_num_ff);
                  finish       = 1'b1;
               end else if (d_last) begin
                  out_load   = 1'b1;
                  res.status = ST_NOTFOUND;
                  finish     = 1'b1;
               end
            end
            if (issue) begin
               ram_ctl.rd_en = 1'b1;
               rd_cnt_in     = rd_cnt_ff + CW'(1);
               rd_addr_in    = rd_addr_inc;
               d_num_in      = rd_cnt_ff + CW'(1);
            end
            if (finish) begin
               d_vld_in = 1'b0;
               state_in = S_IDLE;
            end else if (issue) begin
               d_vld_in = 1'b1;
            end else if (consume) begin
               d_vld_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_in     = res;
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   assign ram_wr_data = req_value;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         front_ff   <= '0;
         occ_ff     <= '0;
         d_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         occ_ff     <= occ_in;
         d_vld_ff   <= d_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      dump_ff    <= dump_in;
      key_ff     <= key_in;
      rd_cnt_ff  <= rd_cnt_in;
      rd_addr_ff <= rd_addr_in;
      d_num_ff   <= d_num_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

endmodule
`default_nettype wire

[rtl/deque_with_search_top.sv]
// Top level of the bounded deque with linear search.
//
//  channel   direction  handshake               payload
//  req       in         req_valid / req_ready   req_func, req_value
//  rsp       out        rsp_valid / rsp_ready   rsp_status, rsp_element, rsp_position, rsp_last
//
// Push, pop and unused codes give one response each; the request is accepted only in idle.
// Dump and search walk the store through the single read port of the element
// memory, one element per cycle while the response register is free to take it.
// Reset clears front index and occupancy; the element store is not cleared.
// A finished response waits in the output register while the next request is taken.
`default_nettype none
module deque_with_search_top #(
   parameter int DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [dws_pkg::FUNC_W-1:0]        req_func,
   input  wire logic signed [dws_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [dws_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [dws_pkg::DATA_W-1:0]      rsp_element,
   output logic [dws_pkg::POS_W-1:0]              rsp_position,
   output logic                                   rsp_last
);
   import dws_pkg::*;

   localparam int AW = $clog2(DEPTH);

   rsp_type                  rsp;
   ram_ctl_type              ram_ctl;
   logic [AW-1:0]            ram_wr_addr;
   logic [AW-1:0]            ram_rd_addr;
   logic signed [DATA_W-1:0] ram_wr_data;
   logic signed [DATA_W-1:0] ram_rd_data;

   dws_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .ram_ctl     (ram_ctl),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   dws_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // unpack the response
   assign rsp_status   = rsp.status;
   assign rsp_element  = rsp.element;
   assign rsp_position = rsp.position;
   assign rsp_last     = rsp.last;

endmodule
`default_nettype wire

[bench/deque_with_search_checker.sv]
// Response checker for the deque with search: predicts every response and compares it.
`timescale 1ns / 1ps
module deque_with_search_checker #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic [dws_pkg::FUNC_W-1:0]          req_func,
   input  wire logic signed [dws_pkg::DATA_W-1:0]   req_value,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [dws_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic signed [dws_pkg::DATA_W-1:0]   rsp_element,
   input  wire logic [dws_pkg::POS_W-1:0]           rsp_position,
   input  wire logic                                rsp_last,
   output int                                       fail_count,
   output int                                       pending,
   output int                                       checked_count,
   output int                                       full_count,
   output int                                       empty_count,
   output int                                       hit_count
);
   import dws_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // shadow copy of the deque
   logic signed [DATA_W-1:0] shadow_store [DEPTH];
   int                       head_slot;
   int                       fill_level;

   // responses still owed by the block, oldest first
   rsp_type                  owed_rsp_q [$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
      full_count    = 0;
      empty_count   = 0;
      hit_count     = 0;
      head_slot     = 0;
      fill_level    = 0;
   end

   // work out every response one request causes and queue them
   task automatic model_request(input logic [FUNC_W-1:0] fn,
                                input logic signed [DATA_W-1:0] key);
      rsp_type r;
      bit      hit;
      r      = '0;
      r.last = 1'b1;
      case (fn)
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (fill_level == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (fn == FN_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  shadow_store[head_slot] = key;
               end else begin
                  shadow_store[(head_slot + fill_level) % DEPTH] = key;
               end
               fill_level++;
            end
            owed_rsp_q.push_back(r);
         end
         FN_POP_FRONT, FN_POP_BACK: begin
            if (fill_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (fn == FN_POP_FRONT) head_slot = (head_slot + 1) % DEPTH;
               fill_level--;
            end
            owed_rsp_q.push_back(r);
         end
         FN_DUMP: begin
            if (fill_level == 0) begin
               r.status = ST_EMPTY;
               owed_rsp_q.push_back(r);
            end else begin
               for (int k = 0; k < fill_level; k++) begin
                  r.element = shadow_store[(head_slot + k) % DEPTH];
                  r.last    = (k == fill_level - 1);
                  owed_rsp_q.push_back(r);
               end
            end
         end
         FN_SEARCH: begin
            if (fill_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               hit = 1'b0;
               for (int k = 0; k < fill_level; k++) begin
                  if (!hit && shadow_store[(head_slot + k) % DEPTH] == key) begin
                     hit        = 1'b1;
                     r.position = POS_W'(k + 1);
                  end
               end
               if (!hit) r.status = ST_NOTFOUND;
            end
            owed_rsp_q.push_back(r);
         end
         default: begin
            // unused codes leave the store alone and answer plain ok
            owed_rsp_q.push_back(r);
         end
      endcase
   endtask

   // compare accepted responses, then predict from accepted requests
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         head_slot  = 0;
         fill_level = 0;
         owed_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (owed_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected response status %0d element %0d position %0d last %0d",
                           $realtime, rsp_status, rsp_element, rsp_position, rsp_last);
            end else begin
               exp_rsp = owed_rsp_q.pop_front();
               if (exp_rsp.status == ST_FULL) full_count++;
               if (exp_rsp.status == ST_EMPTY) empty_count++;
               if (exp_rsp.position != '0) hit_count++;
               if (rsp_status !== exp_rsp.status || rsp_element !== exp_rsp.element ||
                   rsp_position !== exp_rsp.position || rsp_last !== exp_rsp.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch, expected status %0d element %0d position %0d last %0d",
                              $realtime, exp_rsp.status, exp_rsp.element, exp_rsp.position,
                              exp_rsp.last);
                     $display("%0t:           got      status %0d element %0d position %0d last %0d",
                              $realtime, rsp_status, rsp_element, rsp_position, rsp_last);
                  end
               end
            end
         end
         if (req_valid && req_ready) model_request(req_func, req_value);
      end
      pending = owed_rsp_q.size();
   end

endmodule

[bench/deque_with_search_top_tb.sv]
// Testbench top for the deque with search: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module deque_with_search_top_tb;
   import dws_pkg::*;

   localparam int DEPTH         = 16;
   localparam int RANDOM_ITEMS  = 150;
   localparam int PHASE_LEN     = 25;
   localparam int IDLE_LIMIT    = 2000;

   // codes the block does not decode
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

   typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_type;
   typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_mode_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func  = FN_PUSH_FRONT;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic [POS_W-1:0]         rsp_position;
   logic                     rsp_last;

   int       fail_count, pending, checked_count, full_count, empty_count, hit_count;
   int       sent_count   = 0;
   int       burst_left   = 0;
   bit       use_gaps     = 1'b0;
   rx_mode_type rx_mode   = RX_OPEN;
   logic [7:0] rx_tick    = '0;

   deque_with_search_top #(.DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_element(rsp_element),
      .rsp_position(rsp_position), .rsp_last(rsp_last)
   );

   deque_with_search_checker #(.DEPTH(DEPTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_element(rsp_element),
      .rsp_position(rsp_position), .rsp_last(rsp_last),
      .fail_count(fail_count), .pending(pending), .checked_count(checked_count),
      .full_count(full_count), .empty_count(empty_count), .hit_count(hit_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, switching to a new random pattern whenever the low six bits of rx_tick are zero
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick[5:0] == '0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:     rsp_ready <= 1'b1;
         RX_RANDOM:   rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_PERIODIC: rsp_ready <= (rx_tick[1:0] != 2'd0);
         default:     rsp_ready <= (rx_tick[3:0] < 4'd4);
      endcase
   end

   // watchdog: give up after a long stretch with no handshake on either side
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // values biased toward the extremes and a small pool so searches hit
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         4, 5:    return DATA_W'($urandom_range(1, 6));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(input phase_type ph);
      int push_w, pop_w, roll;
      case (ph)
         PH_GROW:   begin push_w = 80; pop_w = 5;  end
         PH_SHRINK: begin push_w = 5;  pop_w = 80; end
         default:   begin push_w = 35; pop_w = 30; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_w) return $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
      if (roll < push_w + pop_w) return $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
      roll = $urandom_range(0, 9);
      if (roll < 3) return FN_DUMP;
      if (roll < 9) return FN_SEARCH;
      return $urandom_range(0, 1) ? FN_SPARE_LO : FN_SPARE_HI;
   endfunction

   // present one request and hold it until accepted; gaps fall between bursts
   task automatic send_req(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] val);
      req_valid <= 1'b1;
      req_func  <= fn;
      req_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (use_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end
   endtask

   // stop sending and wait for every owed response
   task automatic drain_wait();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      phase_type phase;
      int        directed_count;
      phase = PH_GROW;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: everything on an empty store first
      send_req(FN_POP_FRONT, '0);
      send_req(FN_POP_BACK, '0);
      send_req(FN_DUMP, '0);
      send_req(FN_SEARCH, 32'sd5);
      send_req(FN_SPARE_LO, 32'sh7fff_ffff);
      send_req(FN_SPARE_HI, 32'sh8000_0000);
      // extremes at both ends, front push wraps the head index
      send_req(FN_PUSH_FRONT, 32'sh8000_0000);
      send_req(FN_PUSH_BACK, 32'sh7fff_ffff);
      send_req(FN_PUSH_FRONT, '0);
      send_req(FN_PUSH_BACK, -32'sd1);
      // search hit on the last element, hit on the first, and a miss
      send_req(FN_SEARCH, -32'sd1);
      send_req(FN_SEARCH, '0);
      send_req(FN_SEARCH, 32'sh0001_2345);
      send_req(FN_DUMP, '0);
      send_req(FN_POP_FRONT, '0);
      send_req(FN_POP_BACK, '0);
      send_req(FN_DUMP, '0);
      directed_count = sent_count;

      // random: phases that fill to overflow, drain to underflow, and mix
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            if (n == 3 * PHASE_LEN) drain_wait();
            phase    = phase_type'((n / PHASE_LEN) % 3);
            use_gaps = ($urandom_range(0, 3) != 0);
         end
         send_req(pick_func(phase), pick_value());
      end

      drain_wait();
      repeat (DEPTH + 8) @(posedge clock);

      $display("Run covered %0d requests (%0d directed) and %0d checked responses.",
               sent_count, directed_count, checked_count);
      $display("Seen: %0d overflow, %0d empty or underflow, %0d search hits.",
               full_count, empty_count, hit_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures, %0d responses still owed", fail_count, pending);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
